[rtl/mcfam_pkg.sv]
// Shared types and constants of the multi-client FIFO audio mixer.
// Used by mcfam_ctrl, mcfam_datapath and the top level; no dependencies.
package mcfam_pkg;

   localparam int NUM_CLIENTS_DEF  = 4;
   localparam int RING_SAMPLES_DEF = 2048;
   localparam int SAMPLE_BITS_DEF  = 16;

   localparam int OPCODE_W    = 2;
   localparam int CLIENT_ID_W = 3;
   localparam int STATUS_W    = 3;
   localparam int GAIN_W      = 17;
   localparam int CSR_INDEX_W = 2;
   localparam int NUM_GAIN_REGS = 4;
   localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'h10000;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_PULL   = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_PUSHED  = 3'd0,
      ST_DROPPED = 3'd1,
      ST_MIXED   = 3'd2,
      ST_REMOVED = 3'd3,
      ST_INVALID = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_EXEC,
      CS_MIX,
      CS_DRAIN_A,
      CS_DRAIN_B,
      CS_FINISH
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic                   capture;
      logic                   exec;
      logic                   mix_issue;
      logic [CLIENT_ID_W-1:0] mix_client;
      logic                   load_out;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic op_pull;
      logic out_free;
   } dp_status_type;

endpackage

[rtl/multi_client_fifo_audio_mixer.sv]
// Multi-client FIFO audio mixer: one ring FIFO per client in a shared sample
// memory, with per-client gain and a saturating mix. Pushes one sample, pulls one mixed
// sample or removes a client per request. A pull reads the client FIFOs through the
// single memory read port, which visits one client FIFO per cycle, and then passes the
// multiply and accumulate stages. A result waits in an output register, so the next
// request is taken while the previous result is still pending. The user must write
// gains through the csr port (index = client, value clamped to unity) only while no
// request is in work; the block itself does not enforce this. The sample memory
// needs no clearing after reset. Depends on mcfam_pkg, mcfam_ctrl and mcfam_datapath.
module multi_client_fifo_audio_mixer #(
   parameter int NUM_CLIENTS  = mcfam_pkg::NUM_CLIENTS_DEF,
   parameter int RING_SAMPLES = mcfam_pkg::RING_SAMPLES_DEF,
   parameter int SAMPLE_BITS  = mcfam_pkg::SAMPLE_BITS_DEF,
   localparam int REQ_W = ((mcfam_pkg::CLIENT_ID_W + SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [REQ_W-1:0]                    req_tdata,  // client_id, sample_value
   input  logic [mcfam_pkg::OPCODE_W-1:0]      req_tuser,  // opcode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [RSP_W-1:0]                    rsp_tdata,  // mixed_sample
   output logic [mcfam_pkg::STATUS_W-1:0]      rsp_tuser,  // status
   input  logic                                csr_we,
   input  logic [mcfam_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mcfam_pkg::GAIN_W-1:0]        csr_wdata
);
   import mcfam_pkg::*;

   ctrl_cmd_type                  cmd;
   dp_status_type                 sts;
   logic signed [SAMPLE_BITS-1:0] mixed;

   mcfam_ctrl #(
      .NUM_CLIENTS (NUM_CLIENTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mcfam_datapath #(
      .NUM_CLIENTS  (NUM_CLIENTS),
      .RING_SAMPLES (RING_SAMPLES),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_opcode    (req_tuser),
      .req_client_id (req_tdata[CLIENT_ID_W-1:0]),
      .req_sample    (req_tdata[CLIENT_ID_W +: SAMPLE_BITS]),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_status    (rsp_tuser),
      .rsp_mixed     (mixed)
   );

   assign rsp_tdata = RSP_W'(unsigned'(mixed));

endmodule

[rtl/mcfam_ctrl.sv]
// Sequencer of the mixer: request intake, per-client mix loop, result hand-off.
// Depends on mcfam_pkg; drives mcfam_datapath through ctrl_cmd_type.
module mcfam_ctrl #(
   parameter int NUM_CLIENTS = mcfam_pkg::NUM_CLIENTS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  mcfam_pkg::dp_status_type sts,
   output mcfam_pkg::ctrl_cmd_type  cmd
);
   import mcfam_pkg::*;

   localparam int IDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;

   ctrl_state_type   state_ff, state_in;
   logic [IDX_W-1:0] mix_cnt_ff, mix_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= CS_IDLE;
         mix_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         mix_cnt_ff <= mix_cnt_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      mix_cnt_in     = mix_cnt_ff;
      req_tready     = 1'b0;
      cmd            = '0;
      cmd.mix_client = CLIENT_ID_W'(mix_cnt_ff);
      case (state_ff)
         CS_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = CS_EXEC;
            end
         end
         CS_EXEC: begin
            cmd.exec   = 1'b1;
            mix_cnt_in = '0;
            state_in   = sts.op_pull ? CS_MIX : CS_FINISH;
         end
         CS_MIX: begin
            cmd.mix_issue = 1'b1;
            if (mix_cnt_ff == IDX_W'(NUM_CLIENTS - 1)) begin
               state_in = CS_DRAIN_A;
            end else begin
               mix_cnt_in = mix_cnt_ff + 1'b1;
            end
         end
         // product and accumulate stages still in flight
         CS_DRAIN_A: begin
            state_in = CS_DRAIN_B;
         end
         CS_DRAIN_B: begin
            state_in = CS_FINISH;
         end
         CS_FINISH: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   a_exec_after_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> $past(cmd.capture))
      else $error("exec without a captured request");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> sts.out_free)
      else $error("result loaded over a pending result");

   a_mix_runs_into_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.mix_issue |=> (cmd.mix_issue || state_ff == CS_DRAIN_A))
      else $error("mix loop left without draining");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec || cmd.mix_issue || cmd.load_out) |-> !req_tready)
      else $error("request taken while a request is in work");

endmodule

[rtl/mcfam_datapath.sv]
// Datapath of the mixer: sample memory, ring pointers, gains, multiply-accumulate,
// rounding/saturation and the result register. Depends on mcfam_pkg.
module mcfam_datapath #(
   parameter int NUM_CLIENTS  = mcfam_pkg::NUM_CLIENTS_DEF,
   parameter int RING_SAMPLES = mcfam_pkg::RING_SAMPLES_DEF,
   parameter int SAMPLE_BITS  = mcfam_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mcfam_pkg::ctrl_cmd_type             cmd,
   output mcfam_pkg::dp_status_type            sts,
   input  logic [mcfam_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [mcfam_pkg::CLIENT_ID_W-1:0]   req_client_id,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   input  logic                                csr_we,
   input  logic [mcfam_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mcfam_pkg::GAIN_W-1:0]        csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mcfam_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [SAMPLE_BITS-1:0]       rsp_mixed
);
   import mcfam_pkg::*;

   localparam int IDX_W   = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
   localparam int PTR_W   = $clog2(RING_SAMPLES);
   localparam int DEPTH   = NUM_CLIENTS * RING_SAMPLES;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PROD_W  = SAMPLE_BITS + GAIN_W + 1;
   localparam int ACC_W   = PROD_W + 4;
   localparam int SH_W    = ACC_W - 16;
   localparam logic signed [SH_W-1:0] SAT_HI =
      SH_W'((longint'(1) <<< (SAMPLE_BITS - 1)) - longint'(1));
   localparam logic signed [SH_W-1:0] SAT_LO = -SAT_HI - SH_W'(1);
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

   // captured request
   logic [OPCODE_W-1:0]          op_ff;
   logic [CLIENT_ID_W-1:0]       id_ff;
   logic signed [SAMPLE_BITS-1:0] smp_ff;

   // per-client control state
   logic [PTR_W-1:0]  wptr_ff [NUM_CLIENTS];
   logic [PTR_W-1:0]  wptr_in [NUM_CLIENTS];
   logic [PTR_W-1:0]  rptr_ff [NUM_CLIENTS];
   logic [PTR_W-1:0]  rptr_in [NUM_CLIENTS];
   logic              active_ff [NUM_CLIENTS];
   logic              active_in [NUM_CLIENTS];
   logic [GAIN_W-1:0] gain_ff [NUM_CLIENTS];
   logic [GAIN_W-1:0] gain_in [NUM_CLIENTS];

   logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

   logic [IDX_W-1:0]  sel;
   logic              id_ok;
   logic [PTR_W-1:0]  sel_wptr, sel_rptr, wptr_next, rptr_next;
   logic              sel_full, sel_hit, do_write;
   logic [ADDR_W-1:0] base_addr, wr_addr, rd_addr;
   status_type        status_ff, status_in;

   // mix pipeline
   logic                          v1_ff, v1_in, v2_ff, v2_in;
   logic signed [SAMPLE_BITS-1:0] rd_ff;
   logic [GAIN_W-1:0]             g1_ff;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in, acc_rnd;
   logic signed [SH_W-1:0]        acc_sh;
   logic signed [SAMPLE_BITS-1:0] mix_sat;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]           rsp_status_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_mixed_ff;

   assign sel   = cmd.mix_issue ? cmd.mix_client[IDX_W-1:0] : id_ff[IDX_W-1:0];
   assign id_ok = {1'b0, id_ff} < (CLIENT_ID_W + 1)'(NUM_CLIENTS);

   assign sel_wptr  = wptr_ff[sel];
   assign sel_rptr  = rptr_ff[sel];
   assign wptr_next = (sel_wptr == PTR_W'(RING_SAMPLES - 1)) ? '0 : sel_wptr + 1'b1;
   assign rptr_next = (sel_rptr == PTR_W'(RING_SAMPLES - 1)) ? '0 : sel_rptr + 1'b1;
   // one slot stays empty: full when the write pointer would catch the read pointer
   assign sel_full  = (wptr_next == sel_rptr);
   assign sel_hit   = cmd.mix_issue && active_ff[sel] && (sel_wptr != sel_rptr);
   assign do_write  = cmd.exec && (op_ff == OP_PUSH) && id_ok && !sel_full;

   assign base_addr = ADDR_W'(sel) * ADDR_W'(RING_SAMPLES);
   assign wr_addr   = base_addr + ADDR_W'(sel_wptr);
   assign rd_addr   = base_addr + ADDR_W'(sel_rptr);

   always_comb begin
      status_in = status_ff;
      for (int c = 0; c < NUM_CLIENTS; c++) begin
         wptr_in[c]   = wptr_ff[c];
         rptr_in[c]   = rptr_ff[c];
         active_in[c] = active_ff[c];
         gain_in[c]   = gain_ff[c];
         if (csr_we && c < NUM_GAIN_REGS && int'(csr_index) == c) begin
            gain_in[c] = (csr_wdata > GAIN_UNITY) ? GAIN_UNITY : csr_wdata;
         end
      end
      if (cmd.exec) begin
         case (op_ff)
            OP_PUSH: begin
               if (id_ok) begin
                  active_in[sel] = 1'b1;
                  if (sel_full) begin
                     status_in = ST_DROPPED;
                  end else begin
                     wptr_in[sel] = wptr_next;
                     status_in    = ST_PUSHED;
                  end
               end else begin
                  status_in = ST_INVALID;
               end
            end
            OP_PULL: begin
               status_in = ST_MIXED;
            end
            OP_REMOVE: begin
               if (id_ok) begin
                  active_in[sel] = 1'b0;
                  wptr_in[sel]   = '0;
                  rptr_in[sel]   = '0;
                  gain_in[sel]   = GAIN_UNITY;
                  status_in      = ST_REMOVED;
               end else begin
                  status_in = ST_INVALID;
               end
            end
            default: begin
               status_in = ST_INVALID;
            end
         endcase
      end
      if (sel_hit) begin
         rptr_in[sel] = rptr_next;
      end
   end

   assign v1_in   = sel_hit;
   assign v2_in   = v1_ff;
   assign prod_in = PROD_W'(rd_ff) * PROD_W'(signed'({1'b0, g1_ff}));

   always_comb begin
      acc_in = acc_ff;
      if (cmd.exec) begin
         acc_in = '0;
      end else if (v2_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   // round half up, then clip to the sample range
   assign acc_rnd = acc_ff + ROUND_HALF;
   assign acc_sh  = SH_W'(acc_rnd >>> 16);
   always_comb begin
      if (acc_sh > SAT_HI) begin
         mix_sat = SAMPLE_BITS'(SAT_HI);
      end else if (acc_sh < SAT_LO) begin
         mix_sat = SAMPLE_BITS'(SAT_LO);
      end else begin
         mix_sat = SAMPLE_BITS'(acc_sh);
      end
   end

   assign sts.op_pull  = (op_ff == OP_PULL);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLIENTS; c++) begin
            wptr_ff[c]   <= '0;
            rptr_ff[c]   <= '0;
            active_ff[c] <= 1'b0;
            gain_ff[c]   <= GAIN_UNITY;
         end
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int c = 0; c < NUM_CLIENTS; c++) begin
            wptr_ff[c]   <= wptr_in[c];
            rptr_ff[c]   <= rptr_in[c];
            active_ff[c] <= active_in[c];
            gain_ff[c]   <= gain_in[c];
         end
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_opcode;
         id_ff  <= req_client_id;
         smp_ff <= req_sample;
      end
      status_ff <= status_in;
      g1_ff     <= gain_ff[sel];
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      if (cmd.load_out) begin
         rsp_status_ff <= status_ff;
         rsp_mixed_ff  <= (status_ff == ST_MIXED) ? mix_sat : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[wr_addr] <= smp_ff;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_mixed  = rsp_mixed_ff;

   a_no_write_during_mix: assert property (@(posedge clock) disable iff (reset)
      do_write |-> !cmd.mix_issue)
      else $error("sample write collides with mix read");

   a_hit_feeds_product: assert property (@(posedge clock) disable iff (reset)
      sel_hit |=> ##1 v2_ff)
      else $error("mix read lost in pipeline");

   a_mixed_zero_otherwise: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.load_out) && rsp_status_ff != ST_MIXED |-> rsp_mixed_ff == '0)
      else $error("mixed sample set on a non-mix result");

endmodule

[verif/tb_multi_client_fifo_audio_mixer.sv]
// Self-checking testbench for the multi-client FIFO audio mixer.
// Drives directed and random push/pull/remove requests, predicts every response
// in SystemVerilog and compares it; depends on mcfam_pkg and the mixer top level.
module tb_multi_client_fifo_audio_mixer;
   timeunit 1ns;
   timeprecision 1ps;

   import mcfam_pkg::*;

   localparam int CLIENTS   = NUM_CLIENTS_DEF;
   localparam int RING      = RING_SAMPLES_DEF;
   localparam int SMP_W     = SAMPLE_BITS_DEF;
   localparam int PTR_W     = $clog2(RING);
   localparam int REQ_BITS  = ((CLIENT_ID_W + SMP_W + 7) / 8) * 8;
   localparam int RSP_BITS  = ((SMP_W + 7) / 8) * 8;
   localparam int LIMIT     = 600000;
   localparam int PHASE_LEN = 140;
   localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;
   localparam logic [SMP_W-1:0] SMP_MAX = 16'h7FFF;
   localparam logic [SMP_W-1:0] SMP_MIN = 16'h8000;

   typedef struct packed {
      logic [OPCODE_W-1:0]    op;
      logic [CLIENT_ID_W-1:0] id;
      logic [SMP_W-1:0]       smp;
      logic                   known;
      status_type             st;
      logic [SMP_W-1:0]       mix;
   } stim_row;

   typedef struct packed {
      status_type       st;
      logic [SMP_W-1:0] mix;
   } mixer_rsp;

   // after reset every gain is unity, so these rows can be read off directly
   localparam stim_row DIR_ROWS [25] = '{
      '{OP_PULL,     3'd0, 16'h0000, 1'b1, ST_MIXED,   16'h0000},
      '{OP_PUSH,     3'd0, SMP_MAX,  1'b1, ST_PUSHED,  16'h0000},
      '{OP_PUSH,     3'd1, SMP_MAX,  1'b1, ST_PUSHED,  16'h0000},
      '{OP_PULL,     3'd0, 16'h0000, 1'b1, ST_MIXED,   SMP_MAX},
      '{OP_PUSH,     3'd0, SMP_MIN,  1'b1, ST_PUSHED,  16'h0000},
      '{OP_PUSH,     3'd1, SMP_MIN,  1'b1, ST_PUSHED,  16'h0000},
      '{OP_PULL,     3'd0, 16'hFFFF, 1'b1, ST_MIXED,   SMP_MIN},
      '{OP_PUSH,     3'd2, 16'h0001, 1'b1, ST_PUSHED,  16'h0000},
      '{OP_PULL,     3'd7, 16'h5A5A, 1'b1, ST_MIXED,   16'h0001},
      '{OP_PUSH,     3'd4, 16'h1234, 1'b1, ST_INVALID, 16'h0000},
      '{OP_PUSH,     3'd7, 16'hFFFF, 1'b1, ST_INVALID, 16'h0000},
      '{OP_REMOVE,   3'd5, 16'h0000, 1'b1, ST_INVALID, 16'h0000},
      '{OP_REMOVE,   3'd7, 16'hFFFF, 1'b1, ST_INVALID, 16'h0000},
      '{OP_RESERVED, 3'd0, 16'h5555, 1'b1, ST_INVALID, 16'h0000},
      '{OP_PULL,     3'd0, 16'h0000, 1'b1, ST_MIXED,   16'h0000},
      '{OP_PUSH,     3'd3, 16'hFFFF, 1'b1, ST_PUSHED,  16'h0000},
      '{OP_PUSH,     3'd0, 16'h4000, 1'b1, ST_PUSHED,  16'h0000},
      '{OP_PULL,     3'd0, 16'h0000, 1'b0, ST_MIXED,   16'h0000},
      '{OP_REMOVE,   3'd2, 16'h0000, 1'b1, ST_REMOVED, 16'h0000},
      '{OP_REMOVE,   3'd3, 16'h0000, 1'b1, ST_REMOVED, 16'h0000},
      '{OP_PUSH,     3'd2, 16'hAAAA, 1'b0, ST_PUSHED,  16'h0000},
      '{OP_PUSH,     3'd3, 16'h5555, 1'b0, ST_PUSHED,  16'h0000},
      '{OP_REMOVE,   3'd2, 16'h0000, 1'b1, ST_REMOVED, 16'h0000},
      '{OP_PULL,     3'd0, 16'h0000, 1'b0, ST_MIXED,   16'h0000},
      '{OP_PULL,     3'd6, 16'h0000, 1'b1, ST_MIXED,   16'h0000}
   };

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_BITS-1:0]    req_tdata  = '0;
   logic [OPCODE_W-1:0]    req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]    rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [GAIN_W-1:0]      csr_wdata  = '0;

   // mixer shadow state
   logic [SMP_W-1:0]  ring_mem [CLIENTS][RING];
   logic [PTR_W-1:0]  wr_ptr [CLIENTS];
   logic [PTR_W-1:0]  rd_ptr [CLIENTS];
   logic              active [CLIENTS];
   logic [GAIN_W-1:0] gain [CLIENTS];

   mixer_rsp expected_rsp [$];
   bit       steady = 1'b0;
   int       error_count = 0;
   int       n_requests = 0;
   int       n_results = 0;
   int       n_drops = 0;
   int       n_mixes = 0;
   int       cycle_count = 0;

   multi_client_fifo_audio_mixer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic void clear_shadow_client(input int c);
      active[c] = 1'b0;
      wr_ptr[c] = '0;
      rd_ptr[c] = '0;
      gain[c]   = GAIN_UNITY;
   endfunction

   function automatic mixer_rsp compute_mixer_rsp(input logic [OPCODE_W-1:0] op,
         input logic [CLIENT_ID_W-1:0] id, input logic [SMP_W-1:0] smp);
      mixer_rsp r;
      longint acc;
      longint rounded;
      int c;
      c = int'(id);
      r.st  = ST_INVALID;
      r.mix = '0;
      acc   = 0;
      case (op)
         OP_PUSH: begin
            if (c < CLIENTS) begin
               active[c] = 1'b1;
               // one slot stays empty, so a full ring holds RING-1 samples
               if (PTR_W'(wr_ptr[c] - rd_ptr[c]) == PTR_W'(RING - 1)) begin
                  r.st = ST_DROPPED;
               end else begin
                  ring_mem[c][wr_ptr[c]] = smp;
                  wr_ptr[c] = wr_ptr[c] + 1'b1;
                  r.st = ST_PUSHED;
               end
            end
         end
         OP_PULL: begin
            for (int k = 0; k < CLIENTS; k++) begin
               if (active[k] && wr_ptr[k] != rd_ptr[k]) begin
                  acc += longint'($signed(ring_mem[k][rd_ptr[k]])) * longint'(gain[k]);
                  rd_ptr[k] = rd_ptr[k] + 1'b1;
               end
            end
            // round half up, then saturate
            rounded = (acc + 64'sd32768) >>> 16;
            if (rounded > 32767) rounded = 32767;
            else if (rounded < -32768) rounded = -32768;
            r.mix = rounded[SMP_W-1:0];
            r.st  = ST_MIXED;
         end
         OP_REMOVE: begin
            if (c < CLIENTS) begin
               clear_shadow_client(c);
               r.st = ST_REMOVED;
            end
         end
         default: r.st = ST_INVALID;
      endcase
      return r;
   endfunction

   function automatic logic [SMP_W-1:0] pick_sample();
      case ($urandom_range(7))
         0: return SMP_MAX;
         1: return SMP_MIN;
         2: return SMP_W'($urandom_range(15)) - SMP_W'(8);
         default: return SMP_W'($urandom_range(65535));
      endcase
   endfunction

   // Presents one request and returns at the edge where it was taken.
   task automatic send_request(input logic [OPCODE_W-1:0] op,
         input logic [CLIENT_ID_W-1:0] id, input logic [SMP_W-1:0] smp,
         input logic known, input status_type kst, input logic [SMP_W-1:0] kmix);
      mixer_rsp predicted;
      while (!steady && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_BITS'({smp, id});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = compute_mixer_rsp(op, id, smp);
      if (predicted.st == ST_DROPPED) n_drops++;
      if (predicted.st == ST_MIXED) n_mixes++;
      n_requests++;
      if (known) expected_rsp.push_back('{kst, kmix});
      else expected_rsp.push_back(predicted);
   endtask

   task automatic send_random(input logic [OPCODE_W-1:0] op,
         input logic [CLIENT_ID_W-1:0] id, input logic [SMP_W-1:0] smp);
      send_request(op, id, smp, 1'b0, ST_INVALID, '0);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic apply_gains(input logic [GAIN_W-1:0] g0, g1, g2, g3);
      logic [GAIN_W-1:0] vals [4];
      vals[0] = g0;
      vals[1] = g1;
      vals[2] = g2;
      vals[3] = g3;
      for (int i = 0; i < NUM_GAIN_REGS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         if (i < CLIENTS) gain[i] = (vals[i] > GAIN_UNITY) ? GAIN_UNITY : vals[i];
      end
      csr_we <= 1'b0;
   endtask

   task automatic run_random_phase(input int count);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 50) begin
            if ($urandom_range(9) == 0)
               send_random(OP_PUSH, CLIENT_ID_W'($urandom_range(7, CLIENTS)), pick_sample());
            else
               send_random(OP_PUSH, CLIENT_ID_W'($urandom_range(CLIENTS - 1)), pick_sample());
         end else if (r < 85) begin
            send_random(OP_PULL, CLIENT_ID_W'($urandom_range(7)),
                        SMP_W'($urandom_range(65535)));
         end else if (r < 94) begin
            send_random(OP_REMOVE, CLIENT_ID_W'($urandom_range(7)),
                        SMP_W'($urandom_range(65535)));
         end else begin
            send_random(OP_RESERVED, CLIENT_ID_W'($urandom_range(7)),
                        SMP_W'($urandom_range(65535)));
         end
         if ($urandom_range(49) == 0) wait_drained();
      end
   endtask

   // Overfill one client, then drain it past the ring boundary.
   task automatic fill_and_wrap();
      steady = 1'b1;
      repeat (RING + 2) send_random(OP_PUSH, 3'd1, pick_sample());
      repeat (10) send_random(OP_PULL, 3'd0, '0);
      repeat (12) send_random(OP_PUSH, 3'd1, pick_sample());
      repeat (RING + 12) send_random(OP_PULL, 3'd0, '0);
      steady = 1'b0;
   endtask

   always @(posedge clock) begin : rsp_check
      mixer_rsp want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_results++;
            if (expected_rsp.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response, expected none, actual status %0d mix %0h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_tuser !== want.st) begin
                  error_count++;
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.st, rsp_tuser);
               end
               if (rsp_tdata[SMP_W-1:0] !== want.mix) begin
                  error_count++;
                  $display("%0t: mixed_sample mismatch, expected %0h, actual %0h",
                           $time, want.mix, rsp_tdata[SMP_W-1:0]);
               end
            end
         end
         rsp_tready <= steady ? 1'b1 : ($urandom_range(99) >= 21);
      end
   end

   initial begin : watchdog
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout, %0d responses outstanding", $time, expected_rsp.size());
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      for (int c = 0; c < CLIENTS; c++) clear_shadow_client(c);
      reset <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(DIR_ROWS); i++)
         send_request(DIR_ROWS[i].op, DIR_ROWS[i].id, DIR_ROWS[i].smp,
                      DIR_ROWS[i].known, DIR_ROWS[i].st, DIR_ROWS[i].mix);

      // zero, unity, clamped and minimum gain
      wait_drained();
      apply_gains(17'd0, GAIN_UNITY, 17'h1FFFF, 17'd1);
      run_random_phase(PHASE_LEN);

      // half gain everywhere exercises round-half-up
      wait_drained();
      apply_gains(17'h08000, 17'h08000, 17'h08000, 17'h08000);
      fill_and_wrap();
      run_random_phase(PHASE_LEN);

      wait_drained();
      apply_gains(GAIN_W'($urandom_range(65536)), GAIN_W'($urandom_range(65536)),
                  GAIN_W'($urandom_range(65536)), GAIN_W'($urandom_range(65536)));
      run_random_phase(PHASE_LEN);

      wait_drained();
      apply_gains(GAIN_W'($urandom_range(131071)), GAIN_W'($urandom_range(131071)),
                  GAIN_W'($urandom_range(131071)), GAIN_W'($urandom_range(131071)));
      run_random_phase(PHASE_LEN);

      wait_drained();
      apply_gains(GAIN_UNITY, 17'd0, 17'd1, 17'h0FFFF);
      run_random_phase(PHASE_LEN);

      wait_drained();
      repeat (16) @(posedge clock);
      $display("run covered %0d requests over six gain settings: %0d mixes, %0d dropped pushes",
               n_requests, n_mixes, n_drops);
      $display("%0d responses checked, %0d errors", n_results, error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/mcfam_pkg.sv
rtl/mcfam_ctrl.sv
rtl/mcfam_datapath.sv
rtl/multi_client_fifo_audio_mixer.sv
verif/tb_multi_client_fifo_audio_mixer.sv
